>>> rtl/rmts_pkg.sv
// Shared types and constants for the rate monotonic tick scheduler.
// No dependencies.
package rmts_pkg;

    localparam int SLOT_W   = 3;
    localparam int FIELD_W  = 16;
    localparam int BUDGET_W = 24;
    localparam int SUM_W    = BUDGET_W + 1;
    localparam int ACTIVE_W = 4;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] task_period;
        logic [FIELD_W-1:0] task_wcet;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] served_task;
        logic              idle;
    } result_t;

endpackage

>>> rtl/rmts_if.sv
// Channel interfaces: input item, result and configuration write.
// Depends on rmts_pkg.
interface rmts_item_if import rmts_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmts_result_if import rmts_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmts_cfg_if import rmts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTIVE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rmts_pick.sv
// Priority pick: eligible slot with the shortest period, lower slot on ties.
// Parallel pairwise compares, no dependencies.
module rmts_pick #(
    parameter int N  = 8,
    parameter int PW = 16
) (
    input  logic [N-1:0]         eligible,
    input  logic [PW-1:0]        period [N],
    output logic                 found,
    output logic [N-1:0]         win,
    output logic [$clog2(N)-1:0] win_idx
);

    localparam int IW = $clog2(N);

    always_comb
    begin
        win     = '0;
        win_idx = '0;
        for (int k = 0; k < N; k++)
        begin
            win[k] = eligible[k];
            for (int j = 0; j < N; j++)
            begin
                if (j != k && eligible[j])
                begin
                    if (j < k)
                    begin
                        win[k] = win[k] && (period[k] < period[j]);
                    end
                    else
                    begin
                        win[k] = win[k] && (period[k] <= period[j]);
                    end
                end
            end
        end
        for (int k = 0; k < N; k++)
        begin
            if (win[k])
            begin
                win_idx = win_idx | IW'(k);
            end
        end
        found = |eligible;
    end

endmodule

>>> rtl/rate_monotonic_tick_scheduler.sv
// Rate monotonic tick scheduler, top level.
// Path: an input transaction is taken into the input register, then one pass of
// pick and table update writes the result register; a tick holds in the input register while the result is stalled.
// Throughput: one item per cycle while no tick waits on a stalled result; loads give no result.
// Reset: budgets and periods clear, tick sequence restarts, active count 8.
// Depends on rmts_pkg, rmts_if, rmts_pick.
module rate_monotonic_tick_scheduler import rmts_pkg::*; #(
    parameter int MAX_TASKS   = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rmts_item_if.sink     item,
    rmts_result_if.source result,
    rmts_cfg_if.sink      cfg
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int PW = PERIOD_BITS;

    logic [ACTIVE_W-1:0] active_tasks_reg;
    logic                in_valid_reg;
    item_t               in_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                first_tick_reg;

    logic [PW-1:0]       period_reg    [MAX_TASKS];
    logic [FIELD_W-1:0]  wcet_reg      [MAX_TASKS];
    logic [BUDGET_W-1:0] budget_reg    [MAX_TASKS];
    logic [PW-1:0]       countdown_reg [MAX_TASKS];

    logic [PW-1:0]       period_next    [MAX_TASKS];
    logic [FIELD_W-1:0]  wcet_next      [MAX_TASKS];
    logic [BUDGET_W-1:0] budget_next    [MAX_TASKS];
    logic [PW-1:0]       countdown_next [MAX_TASKS];
    logic [BUDGET_W-1:0] budget_dec     [MAX_TASKS];
    logic [SUM_W-1:0]    budget_sum     [MAX_TASKS];
    logic                first_tick_next;

    logic                 exec_fire;
    logic                 is_tick;
    logic                 load_ok;
    logic [MAX_TASKS-1:0] active;
    logic [MAX_TASKS-1:0] eligible;
    logic [MAX_TASKS-1:0] load_hit;
    logic                 found;
    logic [MAX_TASKS-1:0] win;
    logic [IW-1:0]        win_idx;

    assign is_tick   = (in_reg.operation == OP_TICK);
    assign exec_fire = in_valid_reg && (!is_tick || !out_valid_reg || result.ready);
    assign load_ok   = !is_tick && (int'(in_reg.slot) < MAX_TASKS);

    assign item.ready   = !in_valid_reg || exec_fire;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            active[k]   = k < int'(active_tasks_reg);
            eligible[k] = active[k] && (budget_reg[k] != '0);
            load_hit[k] = load_ok && (int'(in_reg.slot) == k);
        end
    end

    rmts_pick #(
        .N  (MAX_TASKS),
        .PW (PW)
    ) u_pick (
        .eligible (eligible),
        .period   (period_reg),
        .found    (found),
        .win      (win),
        .win_idx  (win_idx)
    );

    always_comb
    begin
        first_tick_next = first_tick_reg;
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            period_next[k]    = period_reg[k];
            wcet_next[k]      = wcet_reg[k];
            budget_next[k]    = budget_reg[k];
            countdown_next[k] = countdown_reg[k];
            budget_dec[k]     = budget_reg[k] - BUDGET_W'(win[k]);
            budget_sum[k]     = {1'b0, budget_dec[k]} + SUM_W'(wcet_reg[k]);
        end
        if (is_tick)
        begin
            first_tick_next = 1'b0;
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                budget_next[k] = budget_dec[k];
                if (period_reg[k] != '0)
                begin
                    if (countdown_reg[k] <= PW'(1))
                    begin
                        countdown_next[k] = period_reg[k];
                        if (!first_tick_reg && active[k])
                        begin
                            budget_next[k] = budget_sum[k][BUDGET_W]
                                           ? '1 : budget_sum[k][BUDGET_W-1:0];
                        end
                    end
                    else
                    begin
                        countdown_next[k] = countdown_reg[k] - PW'(1);
                    end
                end
            end
        end
        else if (load_ok)
        begin
            first_tick_next = 1'b1;
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                if (load_hit[k])
                begin
                    period_next[k] = PW'(in_reg.task_period);
                    wcet_next[k]   = in_reg.task_wcet;
                    budget_next[k] = BUDGET_W'(in_reg.task_wcet);
                end
                countdown_next[k] = period_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_tasks_reg <= ACTIVE_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            first_tick_reg   <= 1'b1;
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                budget_reg[k] <= '0;
                period_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                active_tasks_reg <= cfg.data;
            end
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (exec_fire && is_tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (exec_fire)
            begin
                first_tick_reg <= first_tick_next;
                for (int k = 0; k < MAX_TASKS; k++)
                begin
                    budget_reg[k] <= budget_next[k];
                    period_reg[k] <= period_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg <= item.data;
        end
        if (exec_fire && is_tick)
        begin
            out_reg.served_task <= found ? SLOT_W'(win_idx) : '0;
            out_reg.idle        <= !found;
        end
        if (exec_fire)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                wcet_reg[k]      <= wcet_next[k];
                countdown_reg[k] <= countdown_next[k];
            end
        end
    end

endmodule

>>> rtl/rmts_check.sv
// Port-level checks for the rate monotonic tick scheduler, bound to the top.
// Depends on rmts_pkg and rate_monotonic_tick_scheduler.
module rmts_check import rmts_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    item_op,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result transaction dropped or changed while stalled");

    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.idle |-> result_data.served_task == '0)
        else $error("idle result carries a nonzero slot");

    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && item_op == OP_TICK, 2))
        else $error("result appeared without a tick transaction two cycles before");

endmodule

bind rate_monotonic_tick_scheduler rmts_check u_rmts_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_op      (item.data.operation),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

>>> test/tb_rate_monotonic_tick_scheduler.sv
// Self-checking testbench for rate_monotonic_tick_scheduler: directed and random
// load/tick traffic, random back-pressure, and a scoreboard that predicts each pick.
// Depends on rmts_pkg, rmts_if and the scheduler RTL.
module tb_rate_monotonic_tick_scheduler import rmts_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 8;
    localparam int TOTAL_ITEMS = 1000;
    localparam int SETTLE      = 4;
    localparam int LONG_STALL  = 200;
    localparam int STALL_LIMIT = 2000;
    localparam logic [BUDGET_W-1:0] BUDGET_TOP = '1;

    class pick_scoreboard;
        logic [FIELD_W-1:0]  period_tab [SLOTS];
        logic [FIELD_W-1:0]  wcet_tab [SLOTS];
        logic [BUDGET_W-1:0] budget_tab [SLOTS];
        logic [FIELD_W-1:0]  countdown_tab [SLOTS];
        bit                  fresh_seq;
        logic [ACTIVE_W-1:0] active_reg;
        result_t             pick_q [$];
        int                  errors;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                period_tab[k]    = '0;
                wcet_tab[k]      = '0;
                budget_tab[k]    = '0;
                countdown_tab[k] = '0;
            end
            fresh_seq  = 1'b1;
            active_reg = ACTIVE_RESET;
            errors     = 0;
        endfunction

        function void set_active(logic [ACTIVE_W-1:0] v);
            active_reg = v;
        endfunction

        function int pending();
            return pick_q.size();
        endfunction

        // Advance the task table by one accepted input transaction.
        function void take_item(item_t it);
            int          n;
            int          best;
            int          k;
            bit          found;
            logic [SUM_W-1:0] sum;
            result_t     r;
            n = (int'(active_reg) > SLOTS) ? SLOTS : int'(active_reg);
            if (it.operation == OP_LOAD)
            begin
                period_tab[it.slot] = it.task_period;
                wcet_tab[it.slot]   = it.task_wcet;
                budget_tab[it.slot] = {{(BUDGET_W-FIELD_W){1'b0}}, it.task_wcet};
                for (k = 0; k < SLOTS; k++)
                    countdown_tab[k] = period_tab[k];
                fresh_seq = 1'b1;
                return;
            end
            found = 1'b0;
            best  = 0;
            for (k = 0; k < n; k++)
            begin
                if (budget_tab[k] != '0 && (!found || period_tab[k] < period_tab[best]))
                begin
                    best  = k;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                budget_tab[best] = budget_tab[best] - 1'b1;
                r.served_task = best[SLOT_W-1:0];
                r.idle        = 1'b0;
            end
            else
            begin
                r.served_task = '0;
                r.idle        = 1'b1;
            end
            pick_q = {pick_q, r};
            for (k = 0; k < SLOTS; k++)
            begin
                if (period_tab[k] == '0)
                    continue;
                if (countdown_tab[k] <= 1)
                begin
                    countdown_tab[k] = period_tab[k];
                    if (!fresh_seq && k < n)
                    begin
                        sum = budget_tab[k] + wcet_tab[k];
                        budget_tab[k] = (sum > BUDGET_TOP) ? BUDGET_TOP : sum[BUDGET_W-1:0];
                    end
                end
                else
                    countdown_tab[k] = countdown_tab[k] - 1'b1;
            end
            fresh_seq = 1'b0;
        endfunction

        function void check_pick(result_t got);
            result_t want;
            if (pick_q.size() == 0)
            begin
                $error("unexpected result: served_task %0d idle %0d",
                       got.served_task, got.idle);
                errors++;
                return;
            end
            want = pick_q.pop_front();
            if (got.served_task !== want.served_task)
            begin
                $error("served_task: expected %0d actual %0d", want.served_task, got.served_task);
                errors++;
            end
            if (got.idle !== want.idle)
            begin
                $error("idle: expected %0d actual %0d", want.idle, got.idle);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rmts_item_if   item_ch ();
    rmts_result_if result_ch ();
    rmts_cfg_if    cfg_ch ();

    pick_scoreboard board = new();

    int items_sent  = 0;
    int idle_cycles = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit stall_req   = 1'b0;

    rate_monotonic_tick_scheduler #(
        .MAX_TASKS  (SLOTS),
        .PERIOD_BITS(FIELD_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_period();
        int unsigned r;
        r = $urandom_range(0, 49);
        if (r == 0)
            return '0;
        if (r < 40)
            return FIELD_W'($urandom_range(1, 12));
        return FIELD_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [FIELD_W-1:0] rand_wcet();
        if ($urandom_range(0, 9) < 7)
            return FIELD_W'($urandom_range(0, 4));
        return FIELD_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(item_t it);
        int unsigned gap;
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        board.take_item(it);
        items_sent++;
        gap = tx_calm ? 0 : gap_len();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_load(logic [SLOT_W-1:0] s, logic [FIELD_W-1:0] p,
                             logic [FIELD_W-1:0] w);
        item_t it;
        it.operation   = OP_LOAD;
        it.slot        = s;
        it.task_period = p;
        it.task_wcet   = w;
        send_item(it);
    endtask

    task automatic send_tick();
        item_t it;
        it.operation   = OP_TICK;
        it.slot        = SLOT_W'($urandom_range(0, 7));
        it.task_period = FIELD_W'($urandom_range(0, 65535));
        it.task_wcet   = FIELD_W'($urandom_range(0, 65535));
        send_item(it);
    endtask

    // Block goes quiet: every pick out, then a settle wait for a trailing load.
    task automatic drain();
        if (item_ch.valid)
            item_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_active(logic [ACTIVE_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        board.set_active(v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_pick(result_ch.data);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random ready bursts, a long hold-off on request.
    initial
    begin
        int unsigned gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_req = 1'b0;
            end
            else if (rx_calm)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = gap_len();
                if (gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int          phase;
        int          n_loads;
        int          n_ticks;
        int unsigned r;
        logic [ACTIVE_W-1:0] act;

        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme fields, period tie, period zero, odd active counts.
        write_active(4'd8);
        send_load(3'd0, 16'hFFFF, 16'hFFFF);
        send_load(3'd1, 16'd1, 16'd1);
        send_load(3'd2, 16'd0, 16'd3);
        send_load(3'd3, 16'd3, 16'd2);
        send_load(3'd4, 16'd3, 16'd2);
        send_load(3'd5, 16'h8000, 16'd0);
        send_load(3'd6, 16'd7, 16'd1);
        send_load(3'd7, 16'h5555, 16'hAAAA);
        repeat (8) send_tick();
        drain();
        write_active(4'd0);
        repeat (2) send_tick();
        drain();
        write_active(4'd15);
        repeat (2) send_tick();
        drain();
        write_active(4'd1);
        repeat (2) send_tick();

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            phase++;
            drain();
            tx_calm = (phase % 5 == 0);
            rx_calm = (phase % 5 == 0);
            r = $urandom_range(0, 9);
            if (r == 0)
                act = 4'd0;
            else if (r == 1)
                act = ACTIVE_W'($urandom_range(9, 15));
            else
                act = ACTIVE_W'($urandom_range(1, 8));
            if (phase == 2 || phase == 6)
                act = 4'd8;
            if (phase == 4)
                act = 4'd1;
            write_active(act);

            if (phase == 3)
            begin
                // Result side holds off while ticks keep coming until input stalls.
                tx_calm   = 1'b1;
                stall_req = 1'b1;
                while (stall_req)
                    send_tick();
                tx_calm = 1'b0;
            end
            else if (phase == 6)
            begin
                // Budget runs into saturation.
                send_load(3'd0, 16'd1, 16'hFFFF);
                repeat (300) send_tick();
            end
            else
            begin
                n_loads = $urandom_range(1, 4);
                repeat (n_loads)
                    send_load(SLOT_W'($urandom_range(0, 7)), rand_period(), rand_wcet());
                n_ticks = $urandom_range(5, 60);
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_load(SLOT_W'($urandom_range(0, 7)), rand_period(),
                                  rand_wcet());
                    else
                        send_tick();
                end
            end
        end

        tx_calm = 1'b0;
        drain();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rmts_pkg.sv
rtl/rmts_if.sv
rtl/rmts_pick.sv
rtl/rate_monotonic_tick_scheduler.sv
rtl/rmts_check.sv
test/tb_rate_monotonic_tick_scheduler.sv
